@@ rtl/core/battery_voltage_to_percent_assert.svh @@
// Assertion macros shared by the battery voltage to percent RTL
`ifndef BATTERY_VOLTAGE_TO_PERCENT_ASSERT_SVH
`define BATTERY_VOLTAGE_TO_PERCENT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define BVP_ASSERT_NOW(lbl, clk_i, rst_ni, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define BVP_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/bvp_pkg.sv @@
// Package: constants, register codes and shared types of the battery percent block
package bvp_pkg;

  localparam int SAMPLES_DEF = 8;
  localparam int MAX_BP_DEF  = 6;

  localparam int BP_W      = 21;
  localparam int BP_MV_W   = 13;
  localparam int BP_PCT_W  = 8;
  localparam int MV_W      = 12;
  localparam int CODE_W    = 12;
  localparam int SUM_W     = 18;
  localparam int BATT_W    = 16;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 12;
  localparam int PCT_W     = 7;
  localparam int PCT_MAX   = 100;
  localparam int BP_CNT_W  = 3;

  localparam int DIVD_W    = 21;
  localparam int DIVS_W    = 13;
  localparam int DIV_CNT_W = $clog2(DIVD_W);

  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [BP_W-1:0]     BP0_RESET      = 21'd844800;
  localparam logic [BP_W-1:0]     BP1_RESET      = 21'd1075300;
  localparam logic [BP_CNT_W-1:0] BP_COUNT_RESET = 3'd2;
  localparam logic [GAIN_W-1:0]   GAIN_RESET     = 16'd8192;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BP0      = 3'd0,
    REG_BP1      = 3'd1,
    REG_BP2      = 3'd2,
    REG_BP3      = 3'd3,
    REG_BP4      = 3'd4,
    REG_BP5      = 3'd5,
    REG_BP_COUNT = 3'd6,
    REG_DIV_GAIN = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [BP_MV_W-1:0] bp_mv(input logic [BP_W-1:0] bp);
    return bp[BP_W-1:BP_PCT_W];
  endfunction

  function automatic logic [BP_PCT_W-1:0] bp_pct(input logic [BP_W-1:0] bp);
    return bp[BP_PCT_W-1:0];
  endfunction

endpackage

@@ rtl/core/battery_voltage_to_percent.sv @@
// Battery voltage to percent: batch averaging, divider scaling and breakpoint interpolation
//
// Input channel in_*: one ADC sample per item (millivolts and raw code), valid/ready.
// A non-final item of a batch is added to the accumulators. The final item of each batch of
// SAMPLES starts a sequence: average by a constant reciprocal multiply, battery scaling,
// end checks, segment search from the top (up to MAX_BREAKPOINTS-1 segments), and for an
// interior voltage a product, a divide on the bit-serial divider and the output load.
// At or beyond an end breakpoint the search is skipped; a flat segment or no match skips the
// product and the divide. in_ready stays low from the final item until the output load.
// Result channel out_*: one item per batch, held in an output register. Items of the
// next batch are taken while a result waits; only the end of a sequence waits for the
// receiver, so a stalled receiver holds the next batch's sequence, and in_ready with it, so nothing is lost.
// Configuration: APB-style port, register i at byte address 4*i; the user must write
// only when idle, which the block does not enforce. Reset (synchronous, active low)
// clears the accumulators, the sample count and out_valid, and loads register defaults.
module battery_voltage_to_percent #(
  parameter int SAMPLES         = bvp_pkg::SAMPLES_DEF,
  parameter int MAX_BREAKPOINTS = bvp_pkg::MAX_BP_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bvp_pkg::MV_W-1:0]      in_sample_mv,
  input  logic [bvp_pkg::CODE_W-1:0]    in_sample_code,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bvp_pkg::SUM_W-1:0]     out_code_sum,
  output logic [bvp_pkg::MV_W-1:0]      out_average_mv,
  output logic [bvp_pkg::BATT_W-1:0]    out_battery_mv,
  output logic [bvp_pkg::PCT_W-1:0]     out_charge_percent,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bvp_pkg::APB_AW-1:0]    paddr,
  input  logic [bvp_pkg::APB_DW-1:0]    pwdata,
  output logic [bvp_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import bvp_pkg::*;

  `include "battery_voltage_to_percent_assert.svh"

  localparam int CNT_W = $clog2(SAMPLES + 1);
  localparam int IDX_W = $clog2(MAX_BREAKPOINTS);
  localparam int PROD_W = MV_W + GAIN_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES - 1);

  // Rounded-up reciprocal of SAMPLES, exact for every sum of SUM_W bits
  localparam int AVG_SH     = SUM_W + $clog2(SAMPLES);
  localparam int RECIP_W    = SUM_W + 1;
  localparam int AVG_PROD_W = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] AVG_RECIP =
    RECIP_W'(((1 << AVG_SH) + SAMPLES - 1) / SAMPLES);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_AVG    = 8'b00000010,
    S_MUL    = 8'b00000100,
    S_ENDS   = 8'b00001000,
    S_SEARCH = 8'b00010000,
    S_PROD   = 8'b00100000,
    S_DIV2   = 8'b01000000,
    S_FIN    = 8'b10000000
  } state_t;

  logic [MAX_BREAKPOINTS-1:0][BP_W-1:0] bp;
  logic [BP_CNT_W-1:0]                  bp_count;
  logic [GAIN_W-1:0]                    gain;

  div_req_t div_req;
  div_rsp_t div_rsp;

  state_t              state_r;
  logic [SUM_W-1:0]    mv_acc_r;
  logic [SUM_W-1:0]    code_acc_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [SUM_W-1:0]    code_sum_r;
  logic [SUM_W-1:0]    mv_sum_r;
  logic [MV_W-1:0]     avg_r;
  logic [BATT_W-1:0]   batt_r;
  logic [IDX_W-1:0]    seg_r;
  logic [BP_PCT_W-1:0] pct_lo_r;
  logic                neg_r;
  logic [9:0]          pct_raw_r;

  logic                out_valid_r;
  logic [SUM_W-1:0]    out_code_sum_r;
  logic [MV_W-1:0]     out_avg_r;
  logic [BATT_W-1:0]   out_batt_r;
  logic [PCT_W-1:0]    out_pct_r;

  logic                  in_fire;
  logic [SUM_W-1:0]      mv_sum;
  logic [SUM_W-1:0]      code_sum;
  logic [AVG_PROD_W-1:0] avg_prod;
  logic [SUM_W-1:0]      avg_quo;
  logic [BP_CNT_W-1:0]   n_used;
  logic [IDX_W-1:0]      top_idx;
  logic [IDX_W-1:0]      lo_idx;
  logic [BP_MV_W-1:0]    lo_mv;
  logic [BP_MV_W-1:0]    hi_mv;
  logic [BP_PCT_W-1:0]   lo_pct;
  logic [BP_PCT_W-1:0]   hi_pct;
  logic [BP_MV_W-1:0]    top_mv;
  logic [BP_MV_W-1:0]    bot_mv;
  logic                  seg_hit;
  logic [BP_PCT_W-1:0]   dp_mag;
  logic                  dp_neg;
  logic [BP_MV_W-1:0]    dv;
  logic [DIVD_W-1:0]     interp_prod;
  logic [PROD_W-1:0]     batt_prod;
  logic [9:0]            pct_sum;
  logic [PCT_W-1:0]      pct_clamped;
  logic                  out_free;

  bvp_regs #(
    .MAX_BREAKPOINTS (MAX_BREAKPOINTS)
  ) u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .bp       (bp),
    .bp_count (bp_count),
    .gain     (gain)
  );

  bvp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign mv_sum   = mv_acc_r + SUM_W'(in_sample_mv);
  assign code_sum = code_acc_r + SUM_W'(in_sample_code);

  assign avg_prod = mv_sum_r * AVG_RECIP;
  assign avg_quo  = SUM_W'(avg_prod >> AVG_SH);

  // Clamp the breakpoint count into 2..MAX_BREAKPOINTS
  always_comb begin
    priority if (bp_count < BP_CNT_W'(2)) begin
      n_used = BP_CNT_W'(2);
    end else if (bp_count > BP_CNT_W'(MAX_BREAKPOINTS)) begin
      n_used = BP_CNT_W'(MAX_BREAKPOINTS);
    end else begin
      n_used = bp_count;
    end
  end

  assign top_idx = IDX_W'(n_used - 1'b1);
  assign top_mv  = bp_mv(bp[top_idx]);
  assign bot_mv  = bp_mv(bp[0]);

  assign lo_idx  = seg_r - 1'b1;
  assign lo_mv   = bp_mv(bp[lo_idx]);
  assign hi_mv   = bp_mv(bp[seg_r]);
  assign lo_pct  = bp_pct(bp[lo_idx]);
  assign hi_pct  = bp_pct(bp[seg_r]);
  assign seg_hit = (batt_r >= BATT_W'(lo_mv)) && (batt_r <= BATT_W'(hi_mv));

  // Interior voltage lies below the top breakpoint, so it fits the breakpoint width
  assign dp_neg      = hi_pct < lo_pct;
  assign dp_mag      = dp_neg ? (lo_pct - hi_pct) : (hi_pct - lo_pct);
  assign dv          = hi_mv - lo_mv;
  assign interp_prod = DIVD_W'((batt_r[BP_MV_W-1:0] - lo_mv) * dp_mag);

  // Full product of a 12-bit mean and a Q4.12 gain never exceeds 16 integer bits
  assign batt_prod = avg_r * gain;

  assign pct_sum = neg_r ? (10'(pct_lo_r) - 10'(div_rsp.quotient[BP_PCT_W-1:0]))
                         : (10'(pct_lo_r) + 10'(div_rsp.quotient[BP_PCT_W-1:0]));

  always_comb begin
    priority if (pct_raw_r[9]) begin
      pct_clamped = '0;
    end else if (pct_raw_r > 10'(PCT_MAX)) begin
      pct_clamped = PCT_W'(PCT_MAX);
    end else begin
      pct_clamped = pct_raw_r[PCT_W-1:0];
    end
  end

  always_comb begin
    div_req = '0;
    if (state_r == S_PROD) begin
      div_req.start    = 1'b1;
      div_req.dividend = interp_prod;
      div_req.divisor  = dv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      mv_acc_r   <= '0;
      code_acc_r <= '0;
      cnt_r      <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (cnt_r == CNT_LAST) begin
              mv_acc_r   <= '0;
              code_acc_r <= '0;
              cnt_r      <= '0;
              state_r    <= S_AVG;
            end else begin
              mv_acc_r   <= mv_sum;
              code_acc_r <= code_sum;
              cnt_r      <= cnt_r + 1'b1;
            end
          end
        end
        S_AVG: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          state_r <= S_ENDS;
        end
        S_ENDS: begin
          if (batt_r >= BATT_W'(top_mv) || batt_r <= BATT_W'(bot_mv)) begin
            state_r <= S_FIN;
          end else begin
            state_r <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (seg_hit) begin
            state_r <= (dv == '0) ? S_FIN : S_PROD;
          end else if (seg_r == IDX_W'(1)) begin
            state_r <= S_FIN;
          end
        end
        S_PROD: begin
          state_r <= S_DIV2;
        end
        S_DIV2: begin
          if (div_rsp.done) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Working registers of the sequence
  always_ff @(posedge clk) begin
    if (in_fire && cnt_r == CNT_LAST) begin
      code_sum_r <= code_sum;
      mv_sum_r   <= mv_sum;
    end
    if (state_r == S_AVG) begin
      avg_r <= (|avg_quo[SUM_W-1:MV_W]) ? '1 : avg_quo[MV_W-1:0];
    end
    if (state_r == S_MUL) begin
      batt_r <= batt_prod[GAIN_FRAC +: BATT_W];
    end
    if (state_r == S_ENDS) begin
      seg_r <= top_idx;
      priority if (batt_r >= BATT_W'(top_mv)) begin
        pct_raw_r <= 10'(bp_pct(bp[top_idx]));
      end else if (batt_r <= BATT_W'(bot_mv)) begin
        pct_raw_r <= 10'(bp_pct(bp[0]));
      end else begin
        pct_raw_r <= '0;
      end
    end
    if (state_r == S_SEARCH) begin
      if (seg_hit) begin
        pct_raw_r <= 10'(lo_pct);
      end else if (seg_r != IDX_W'(1)) begin
        seg_r <= seg_r - 1'b1;
      end
    end
    if (state_r == S_PROD) begin
      pct_lo_r <= lo_pct;
      neg_r    <= dp_neg;
    end
    if (state_r == S_DIV2 && div_rsp.done) begin
      pct_raw_r <= pct_sum;
    end
  end

  // Output register: hold until taken, load at the end of a sequence
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      out_code_sum_r <= code_sum_r;
      out_avg_r      <= avg_r;
      out_batt_r     <= batt_r;
      out_pct_r      <= pct_clamped;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_code_sum       = out_code_sum_r;
  assign out_average_mv     = out_avg_r;
  assign out_battery_mv     = out_batt_r;
  assign out_charge_percent = out_pct_r;

  `BVP_ASSERT_NEXT(a_last_starts_avg, clk, rst_n, in_fire && cnt_r == CNT_LAST, state_r == S_AVG, "final item did not start averaging")
  `BVP_ASSERT_NOW(a_done_expected, clk, rst_n, div_rsp.done, state_r == S_DIV2, "divider result with no waiting step")
  `BVP_ASSERT_NOW(a_pct_range, clk, rst_n, out_valid_r, out_charge_percent <= PCT_W'(PCT_MAX), "percent above full scale")
  `BVP_ASSERT_NOW(a_search_index, clk, rst_n, state_r == S_SEARCH, seg_r != '0 && seg_r <= top_idx, "segment index out of table")

endmodule

@@ rtl/core/bvp_regs.sv @@
// Configuration register file behind the APB-style port
module bvp_regs #(
  parameter int MAX_BREAKPOINTS = bvp_pkg::MAX_BP_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           psel,
  input  logic                                           penable,
  input  logic                                           pwrite,
  input  logic [bvp_pkg::APB_AW-1:0]                     paddr,
  input  logic [bvp_pkg::APB_DW-1:0]                     pwdata,
  output logic [bvp_pkg::APB_DW-1:0]                     prdata,
  output logic                                           pready,
  output logic [MAX_BREAKPOINTS-1:0][bvp_pkg::BP_W-1:0]  bp,
  output logic [bvp_pkg::BP_CNT_W-1:0]                   bp_count,
  output logic [bvp_pkg::GAIN_W-1:0]                     gain
);
  import bvp_pkg::*;

  localparam int IDX_W = $clog2(MAX_BREAKPOINTS);

  logic [MAX_BREAKPOINTS-1:0][BP_W-1:0] bp_r;
  logic [BP_CNT_W-1:0]                  bp_count_r;
  logic [GAIN_W-1:0]                    gain_r;
  logic [REG_IDX_W-1:0]                 idx;
  logic                                 wr_en;
  logic                                 idx_is_bp;

  assign pready    = 1'b1;
  assign idx       = paddr[APB_AW-1:2];
  assign wr_en     = psel && penable && pwrite && pready;
  assign idx_is_bp = (idx < REG_BP_COUNT) && (idx < REG_IDX_W'(MAX_BREAKPOINTS));

  for (genvar i = 0; i < MAX_BREAKPOINTS; i++) begin : g_bp
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        bp_r[i] <= (i == 0) ? BP0_RESET : ((i == 1) ? BP1_RESET : '0);
      end else if (wr_en && idx == REG_IDX_W'(i)) begin
        bp_r[i] <= pwdata[BP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_count_r <= BP_COUNT_RESET;
      gain_r     <= GAIN_RESET;
    end else if (wr_en) begin
      if (idx == REG_BP_COUNT) begin
        bp_count_r <= pwdata[BP_CNT_W-1:0];
      end
      if (idx == REG_DIV_GAIN) begin
        gain_r <= pwdata[GAIN_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    priority if (idx_is_bp) begin
      prdata = APB_DW'(bp_r[idx[IDX_W-1:0]]);
    end else if (idx == REG_BP_COUNT) begin
      prdata = APB_DW'(bp_count_r);
    end else if (idx == REG_DIV_GAIN) begin
      prdata = APB_DW'(gain_r);
    end else begin
      prdata = '0;
    end
  end

  assign bp       = bp_r;
  assign bp_count = bp_count_r;
  assign gain     = gain_r;

endmodule

@@ rtl/core/bvp_div.sv @@
// Restoring divider, one quotient bit per cycle
module bvp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  bvp_pkg::div_req_t req,
  output bvp_pkg::div_rsp_t rsp
);
  import bvp_pkg::*;

  `include "battery_voltage_to_percent_assert.svh"

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIVS_W-1:0]    rem_r;
  logic [DIVS_W-1:0]    divisor_r;
  logic [DIVD_W-1:0]    quo_r;
  logic [DIVS_W:0]      rem_sh;
  logic                 fits;

  // Bring down the next dividend bit and try the subtraction
  assign rem_sh = {rem_r, quo_r[DIVD_W-1]};
  assign fits   = rem_sh >= {1'b0, divisor_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r     <= '0;
      quo_r     <= req.dividend;
      divisor_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? DIVS_W'(rem_sh - {1'b0, divisor_r}) : rem_sh[DIVS_W-1:0];
      quo_r <= {quo_r[DIVD_W-2:0], fits};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  `BVP_ASSERT_NOW(a_start_when_free, clk, rst_n, req.start, !busy_r, "divider started while busy")
  `BVP_ASSERT_NEXT(a_done_single, clk, rst_n, done_r, !done_r && !busy_r, "divider done repeated")
  `BVP_ASSERT_NOW(a_rem_bound, clk, rst_n, busy_r, rem_r < divisor_r, "remainder not below divisor")

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the battery voltage to percent block
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bvp_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int RESET_CYCLES = 12;
  localparam int BATCH = SAMPLES_DEF;
  localparam int MAX_BP = MAX_BP_DEF;
  localparam int TABLE_SLOTS = 6;
  localparam int SETTLE_CYCLES = 64;
  localparam int LIMIT_CYCLES = 400000;
  localparam int BATCHES_PER_SETTING = 25;
  localparam int MV_TOP = (1 << MV_W) - 1;
  localparam int BP_MV_TOP = (1 << BP_MV_W) - 1;
  localparam int BATT_TOP = (1 << BATT_W) - 1;

  typedef struct {
    logic [SUM_W-1:0]  code_sum;
    logic [MV_W-1:0]   average_mv;
    logic [BATT_W-1:0] battery_mv;
    logic [PCT_W-1:0]  charge_percent;
  } batch_reading_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [MV_W-1:0]     in_sample_mv = '0;
  logic [CODE_W-1:0]   in_sample_code = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [SUM_W-1:0]    out_code_sum;
  logic [MV_W-1:0]     out_average_mv;
  logic [BATT_W-1:0]   out_battery_mv;
  logic [PCT_W-1:0]    out_charge_percent;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  // Shadow copy of the registers and the batch accumulators
  logic [BP_W-1:0]     bp_regs [TABLE_SLOTS];
  logic [BP_CNT_W-1:0] count_reg;
  logic [GAIN_W-1:0]   gain_reg;
  logic [SUM_W-1:0]    mv_total = '0;
  logic [SUM_W-1:0]    code_total = '0;
  int                  batch_fill = 0;

  int                  staged_volt [TABLE_SLOTS];
  int                  staged_pct [TABLE_SLOTS];
  batch_reading_t      readings_due [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count = 0;
  int samples_sent = 0;
  int readings_checked = 0;
  int settings_loaded = 0;
  int cycle_count = 0;

  battery_voltage_to_percent #(
    .SAMPLES(SAMPLES_DEF),
    .MAX_BREAKPOINTS(MAX_BP_DEF)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_sample_mv(in_sample_mv),
    .in_sample_code(in_sample_code),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_code_sum(out_code_sum),
    .out_average_mv(out_average_mv),
    .out_battery_mv(out_battery_mv),
    .out_charge_percent(out_charge_percent),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int bp_volt(input int slot);
    return int'(bp_regs[slot][BP_W-1:BP_PCT_W]);
  endfunction

  function automatic int bp_charge(input int slot);
    return int'(bp_regs[slot][BP_PCT_W-1:0]);
  endfunction

  // Top and bottom clamp, then search the segments from the top
  function automatic int percent_from_table(input int v);
    int     n;
    longint lo, hi, dv, dp, r;
    n = int'(count_reg);
    if (n < 2) n = 2;
    if (n > MAX_BP) n = MAX_BP;
    if (v >= bp_volt(n - 1)) return bp_charge(n - 1);
    if (v <= bp_volt(0)) return bp_charge(0);
    for (int i = n - 1; i > 0; i--) begin
      lo = bp_volt(i - 1);
      hi = bp_volt(i);
      if (v >= lo && v <= hi) begin
        dv = hi - lo;
        dp = longint'(bp_charge(i)) - longint'(bp_charge(i - 1));
        if (dv == 0) return bp_charge(i - 1);
        r = ((longint'(v) - lo) * dp) / dv + longint'(bp_charge(i - 1));
        if (r < 0) r = 0;
        return int'(r);
      end
    end
    return 0;
  endfunction

  function automatic void accumulate_sample(input logic [MV_W-1:0] mv,
                                            input logic [CODE_W-1:0] code);
    batch_reading_t reading;
    int             avg, pct;
    longint         scaled;
    mv_total = mv_total + mv;
    code_total = code_total + code;
    batch_fill++;
    if (batch_fill < BATCH) return;
    avg = int'(mv_total) / BATCH;
    if (avg > MV_TOP) avg = MV_TOP;
    scaled = (longint'(avg) * longint'(gain_reg)) >> GAIN_FRAC;
    if (scaled > BATT_TOP) scaled = BATT_TOP;
    pct = percent_from_table(int'(scaled));
    if (pct > PCT_MAX) pct = PCT_MAX;
    reading.code_sum = code_total;
    reading.average_mv = MV_W'(avg);
    reading.battery_mv = BATT_W'(scaled);
    reading.charge_percent = PCT_W'(pct);
    readings_due.push_back(reading);
    mv_total = '0;
    code_total = '0;
    batch_fill = 0;
  endfunction

  function automatic void store_register(input reg_idx_t idx, input logic [APB_DW-1:0] value);
    case (idx)
      REG_BP0, REG_BP1, REG_BP2, REG_BP3, REG_BP4, REG_BP5: begin
        bp_regs[int'(idx) - int'(REG_BP0)] = value[BP_W-1:0];
      end
      REG_BP_COUNT: begin
        count_reg = value[BP_CNT_W-1:0];
      end
      REG_DIV_GAIN: begin
        gain_reg = value[GAIN_W-1:0];
      end
      default: begin
      end
    endcase
  endfunction

  // Half the time fill the unused upper bits with noise
  function automatic logic [APB_DW-1:0] pad_upper(input int width, input logic [APB_DW-1:0] field);
    logic [APB_DW-1:0] noise;
    noise = $urandom_range(1) ? (APB_DW'($urandom()) << width) : '0;
    return noise | field;
  endfunction

  function automatic void compare_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      error_count++;
    end
  endfunction

  task automatic check_reading();
    batch_reading_t want;
    if (readings_due.size() == 0) begin
      $display("%0t: unexpected result, expected none, got code_sum %0d average_mv %0d",
               $time, out_code_sum, out_average_mv);
      error_count++;
    end else begin
      want = readings_due.pop_front();
      readings_checked++;
      compare_field("code_sum", 32'(want.code_sum), 32'(out_code_sum));
      compare_field("average_mv", 32'(want.average_mv), 32'(out_average_mv));
      compare_field("battery_mv", 32'(want.battery_mv), 32'(out_battery_mv));
      compare_field("charge_percent", 32'(want.charge_percent), 32'(out_charge_percent));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_reading();
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_sample(input logic [MV_W-1:0] mv, input logic [CODE_W-1:0] code);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_sample_mv <= mv;
    in_sample_code <= code;
    do @(posedge clk); while (!in_ready);
    accumulate_sample(mv, code);
    samples_sent++;
  endtask

  // Drop valid, let every reading come back, then let the block settle
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    store_register(idx, value);
  endtask

  task automatic load_settings(input int count, input int gain);
    logic [BP_W-1:0] packed_bp;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      packed_bp = {BP_MV_W'(staged_volt[i]), BP_PCT_W'(staged_pct[i])};
      write_reg(reg_idx_t'(int'(REG_BP0) + i), pad_upper(BP_W, APB_DW'(packed_bp)));
    end
    write_reg(REG_BP_COUNT, pad_upper(BP_CNT_W, APB_DW'(count)));
    write_reg(REG_DIV_GAIN, pad_upper(GAIN_W, APB_DW'(gain)));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    settings_loaded++;
  endtask

  task automatic stage_ordered_table(input int span, input int pct_cap, input bit repeats);
    int volts[$];
    int pcts[$];
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      volts.push_back($urandom_range(span));
      pcts.push_back($urandom_range(pct_cap));
    end
    volts.sort();
    pcts.sort();
    // Repeat a voltage to give flat segments while keeping the order
    if (repeats) begin
      volts[2] = volts[1];
      volts[4] = volts[3];
    end
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      staged_volt[i] = volts[i];
      staged_pct[i] = pcts[i];
    end
  endtask

  task automatic stage_unordered_table();
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      staged_volt[i] = $urandom_range(BP_MV_TOP);
      staged_pct[i] = $urandom_range(255);
    end
  endtask

  // Mix of uniform batches and batches aimed at a breakpoint or a random voltage
  task automatic send_random_batches(input int batches);
    int mode, target, centre, spread, mv;
    for (int b = 0; b < batches; b++) begin
      mode = $urandom_range(2);
      if ($urandom_range(1)) target = bp_volt($urandom_range(TABLE_SLOTS - 1));
      else target = $urandom_range(BP_MV_TOP);
      if (gain_reg == 0) centre = $urandom_range(MV_TOP);
      else centre = (target * (1 << GAIN_FRAC) + int'(gain_reg) - 1) / int'(gain_reg);
      if (centre > MV_TOP) centre = MV_TOP;
      spread = (mode == 1) ? 0 : 6;
      for (int s = 0; s < BATCH; s++) begin
        if (mode == 0) begin
          mv = $urandom_range(MV_TOP);
        end else begin
          mv = centre + $urandom_range(2 * spread) - spread;
          if (mv < 0) mv = 0;
          if (mv > MV_TOP) mv = MV_TOP;
        end
        send_sample(MV_W'(mv), CODE_W'($urandom_range(MV_TOP)));
      end
    end
  endtask

  // Default table: zero reading, full-scale reading, alternating bits inside the table
  task automatic test_reset_defaults();
    for (int s = 0; s < BATCH; s++) send_sample('0, '0);
    for (int s = 0; s < BATCH; s++) send_sample('1, '1);
    for (int s = 0; s < BATCH; s++) begin
      send_sample((s % 2) ? MV_W'(12'h555) : MV_W'(12'hAAA),
                  (s % 2) ? CODE_W'(12'hAAA) : CODE_W'(12'h555));
    end
    wait_for_idle();
  endtask

  task automatic test_extreme_registers();
    stage_ordered_table(BP_MV_TOP, 255, 1'b0);
    load_settings(7, 65535);
    send_random_batches(BATCHES_PER_SETTING);
    wait_for_idle();
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      staged_volt[i] = BP_MV_TOP;
      staged_pct[i] = 255;
    end
    load_settings(0, 0);
    send_random_batches(BATCHES_PER_SETTING);
    wait_for_idle();
  endtask

  task automatic test_ordered_tables();
    stage_ordered_table(MV_TOP, PCT_MAX, 1'b0);
    load_settings(MAX_BP, 1 << GAIN_FRAC);
    send_random_batches(BATCHES_PER_SETTING);
    wait_for_idle();
    stage_ordered_table(BP_MV_TOP, 255, 1'b1);
    load_settings($urandom_range(5, 2), $urandom_range(16384, 2048));
    send_random_batches(BATCHES_PER_SETTING);
    wait_for_idle();
  endtask

  task automatic test_unordered_tables();
    stage_unordered_table();
    load_settings(MAX_BP, $urandom_range(16384, 2048));
    send_random_batches(BATCHES_PER_SETTING);
    wait_for_idle();
    stage_unordered_table();
    load_settings(1, $urandom_range(65535));
    send_random_batches(BATCHES_PER_SETTING);
    wait_for_idle();
  endtask

  initial begin
    bp_regs[0] = BP0_RESET;
    bp_regs[1] = BP1_RESET;
    for (int i = 2; i < TABLE_SLOTS; i++) bp_regs[i] = '0;
    count_reg = BP_COUNT_RESET;
    gain_reg = GAIN_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 13;
    recv_idle_pct = 88;
    test_reset_defaults();
    test_extreme_registers();
    send_idle_pct = 88;
    recv_idle_pct = 13;
    test_ordered_tables();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_unordered_tables();

    $display("Sent %0d samples, checked %0d batch readings over %0d register settings",
             samples_sent, readings_checked, settings_loaded + 1);
    $display("Tables covered: defaults, extremes, ascending, flat segments, unordered");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/bvp_pkg.sv
rtl/core/bvp_regs.sv
rtl/core/bvp_div.sv
rtl/core/battery_voltage_to_percent.sv
dv/tb.sv
